// File: rtl/sfcs_pkg.sv
package sfcs_pkg;

  // Request codes as they arrive on the host side.
  typedef enum logic [2:0] {
    OpRead      = 3'd0,
    OpPair      = 3'd1,
    OpFinish    = 3'd2,
    OpErase4k   = 3'd3,
    OpErase64k  = 3'd4,
    OpChipErase = 3'd5,
    OpStatus    = 3'd6
  } op_e;

  // Command kinds after classification; a program pair splits into first and later.
  typedef enum logic [2:0] {
    CmdRead      = 3'd0,
    CmdPairFirst = 3'd1,
    CmdPairNext  = 3'd2,
    CmdFinish    = 3'd3,
    CmdErase4k   = 3'd4,
    CmdErase64k  = 3'd5,
    CmdChipErase = 3'd6,
    CmdStatus    = 3'd7
  } cmd_e;

  typedef enum logic {
    BackIdle = 1'b0,
    BackRun  = 1'b1
  } back_state_e;

  localparam int unsigned MaxRead    = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned StepW      = 6;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

  // Flash opcodes and fixed frame bytes.
  localparam logic [7:0] FlWriteEnable  = 8'h06;
  localparam logic [7:0] FlWriteDisable = 8'h04;
  localparam logic [7:0] FlRead         = 8'h03;
  localparam logic [7:0] FlFastRead     = 8'h0B;
  localparam logic [7:0] FlErase4k      = 8'h20;
  localparam logic [7:0] FlErase64k     = 8'hD8;
  localparam logic [7:0] FlChipErase    = 8'h60;
  localparam logic [7:0] FlAaiProgram   = 8'hAD;
  localparam logic [7:0] FlReadStatus   = 8'h05;
  localparam logic [7:0] FlBusyEnable   = 8'h70;
  localparam logic [7:0] FlBusyDisable  = 8'h80;
  localparam logic [7:0] FlStatusUnlock = 8'h50;
  localparam logic [7:0] FlWriteStatus  = 8'h01;
  localparam logic [7:0] FlStatusOpen   = 8'h00;
  localparam logic [7:0] FlStatusLock   = 8'h1C;

  typedef struct packed {
    cmd_e              kind;
    logic [23:0]       address;
    logic [7:0]        data_first;
    logic [7:0]        data_second;
    logic [LenW-1:0]   read_length;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } push_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       frame_end;
    logic       capture;
    logic       last;
  } slot_t;

endpackage

// File: rtl/sfcs_front.sv
module sfcs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    opcode_i,
  input  logic [23:0]                   address_i,
  input  logic [7:0]                    data_first_i,
  input  logic [7:0]                    data_second_i,
  input  logic [sfcs_pkg::LenW-1:0]     read_length_i,
  output sfcs_pkg::push_t               push_o,
  input  logic                          push_ready_i
);

  logic aai_open_q, aai_open_d;
  logic accept;
  sfcs_pkg::desc_t desc;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classify the request and saturate the read length.
  always_comb begin
    desc.address     = address_i;
    desc.data_first  = data_first_i;
    desc.data_second = data_second_i;
    if (read_length_i > sfcs_pkg::LenW'(sfcs_pkg::MaxRead)) begin
      desc.read_length = sfcs_pkg::LenW'(sfcs_pkg::MaxRead);
    end else begin
      desc.read_length = read_length_i;
    end
    push_o.valid = accept;
    aai_open_d   = aai_open_q;
    desc.kind    = sfcs_pkg::CmdRead;
    case (opcode_i)
      sfcs_pkg::OpRead: desc.kind = sfcs_pkg::CmdRead;
      sfcs_pkg::OpPair: begin
        desc.kind = aai_open_q ? sfcs_pkg::CmdPairNext : sfcs_pkg::CmdPairFirst;
        if (accept) begin
          aai_open_d = 1'b1;
        end
      end
      sfcs_pkg::OpFinish: begin
        desc.kind = sfcs_pkg::CmdFinish;
        if (accept) begin
          aai_open_d = 1'b0;
        end
      end
      sfcs_pkg::OpErase4k:   desc.kind = sfcs_pkg::CmdErase4k;
      sfcs_pkg::OpErase64k:  desc.kind = sfcs_pkg::CmdErase64k;
      sfcs_pkg::OpChipErase: desc.kind = sfcs_pkg::CmdChipErase;
      sfcs_pkg::OpStatus:    desc.kind = sfcs_pkg::CmdStatus;
      default: begin
        // Unused request code: taken and dropped.
        push_o.valid = 1'b0;
      end
    endcase
    push_o.desc = desc;
  end

  // Program sequence tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aai_open_q <= 1'b0;
    end else begin
      aai_open_q <= aai_open_d;
    end
  end

endmodule

// File: rtl/sfcs_fifo.sv
module sfcs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sfcs_pkg::push_t push_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output sfcs_pkg::desc_t pop_desc_o,
  input  logic            pop_i
);

  sfcs_pkg::desc_t mem_q [sfcs_pkg::QueueDepth];
  logic [sfcs_pkg::QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [sfcs_pkg::QueueCw-1:0] count_q;
  logic do_push, do_pop;

  assign push_ready_o = (count_q != sfcs_pkg::QueueCw'(sfcs_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_desc_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == sfcs_pkg::QueueAw'(sfcs_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == sfcs_pkg::QueueAw'(sfcs_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.desc;
    end
  end

endmodule

// File: rtl/sfcs_back.sv
module sfcs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fast_read_i,
  input  logic            desc_valid_i,
  input  sfcs_pkg::desc_t desc_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      mosi_byte_o,
  output logic            frame_end_o,
  output logic            capture_o,
  output logic            last_o
);

  sfcs_pkg::back_state_e state_q, state_d;
  sfcs_pkg::desc_t desc_q;
  logic [sfcs_pkg::StepW-1:0] step_q;
  logic out_valid_q;
  sfcs_pkg::slot_t out_q;
  sfcs_pkg::slot_t slot;
  logic load;

  // Address byte by index: one is the high byte, three the low byte.
  function automatic logic [7:0] addr_byte(input logic [23:0] addr, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd1:    b = addr[23:16];
      2'd2:    b = addr[15:8];
      default: b = addr[7:0];
    endcase
    return b;
  endfunction

  // Slot contents for the current command and step.
  always_comb begin
    logic [sfcs_pkg::StepW-1:0] hdr;
    logic [sfcs_pkg::StepW-1:0] last_step;
    logic [sfcs_pkg::StepW-1:0] ofs;
    hdr       = fast_read_i ? sfcs_pkg::StepW'(5) : sfcs_pkg::StepW'(4);
    last_step = hdr + sfcs_pkg::StepW'(desc_q.read_length) - 1'b1;
    ofs       = '0;
    slot      = '0;
    case (desc_q.kind)
      sfcs_pkg::CmdRead: begin
        slot.last = (step_q == last_step);
        if (step_q == '0) begin
          slot.mosi_byte = fast_read_i ? sfcs_pkg::FlFastRead : sfcs_pkg::FlRead;
        end else if (step_q <= sfcs_pkg::StepW'(3)) begin
          slot.mosi_byte = addr_byte(desc_q.address, step_q[1:0]);
          slot.frame_end = (step_q == sfcs_pkg::StepW'(3)) && !fast_read_i &&
                           (desc_q.read_length == '0);
        end else if (fast_read_i && step_q == sfcs_pkg::StepW'(4)) begin
          slot.frame_end = (desc_q.read_length == '0);
        end else begin
          slot.capture   = 1'b1;
          slot.frame_end = (step_q == last_step);
        end
      end
      sfcs_pkg::CmdPairFirst: begin
        ofs = step_q - sfcs_pkg::StepW'(5);
        case (step_q)
          6'd0: slot = '{sfcs_pkg::FlStatusUnlock, 1'b1, 1'b0, 1'b0};
          6'd1: slot = '{sfcs_pkg::FlWriteStatus, 1'b0, 1'b0, 1'b0};
          6'd2: slot = '{sfcs_pkg::FlStatusOpen, 1'b1, 1'b0, 1'b0};
          6'd3: slot = '{sfcs_pkg::FlBusyEnable, 1'b1, 1'b0, 1'b0};
          6'd4: slot = '{sfcs_pkg::FlWriteEnable, 1'b1, 1'b0, 1'b0};
          6'd5: slot = '{sfcs_pkg::FlAaiProgram, 1'b0, 1'b0, 1'b0};
          6'd6, 6'd7, 6'd8:
            slot = '{addr_byte(desc_q.address, ofs[1:0]), 1'b0, 1'b0, 1'b0};
          6'd9: slot = '{desc_q.data_first, 1'b0, 1'b0, 1'b0};
          default: slot = '{desc_q.data_second, 1'b1, 1'b0, 1'b1};
        endcase
      end
      sfcs_pkg::CmdPairNext: begin
        case (step_q)
          6'd0:    slot = '{sfcs_pkg::FlAaiProgram, 1'b0, 1'b0, 1'b0};
          6'd1:    slot = '{desc_q.data_first, 1'b0, 1'b0, 1'b0};
          default: slot = '{desc_q.data_second, 1'b1, 1'b0, 1'b1};
        endcase
      end
      sfcs_pkg::CmdFinish: begin
        case (step_q)
          6'd0:    slot = '{sfcs_pkg::FlWriteDisable, 1'b1, 1'b0, 1'b0};
          6'd1:    slot = '{sfcs_pkg::FlBusyDisable, 1'b1, 1'b0, 1'b0};
          6'd2:    slot = '{sfcs_pkg::FlWriteStatus, 1'b0, 1'b0, 1'b0};
          default: slot = '{sfcs_pkg::FlStatusLock, 1'b1, 1'b0, 1'b1};
        endcase
      end
      sfcs_pkg::CmdErase4k, sfcs_pkg::CmdErase64k: begin
        ofs = step_q - 1'b1;
        case (step_q)
          6'd0: slot = '{sfcs_pkg::FlWriteEnable, 1'b1, 1'b0, 1'b0};
          6'd1: slot = '{(desc_q.kind == sfcs_pkg::CmdErase4k) ?
                         sfcs_pkg::FlErase4k : sfcs_pkg::FlErase64k, 1'b0, 1'b0, 1'b0};
          6'd2, 6'd3:
            slot = '{addr_byte(desc_q.address, ofs[1:0]), 1'b0, 1'b0, 1'b0};
          default: slot = '{desc_q.address[7:0], 1'b1, 1'b0, 1'b1};
        endcase
      end
      sfcs_pkg::CmdChipErase: begin
        if (step_q == '0) begin
          slot = '{sfcs_pkg::FlWriteEnable, 1'b1, 1'b0, 1'b0};
        end else begin
          slot = '{sfcs_pkg::FlChipErase, 1'b1, 1'b0, 1'b1};
        end
      end
      default: begin
        // Status read: opcode, then one capture slot.
        if (step_q == '0) begin
          slot = '{sfcs_pkg::FlReadStatus, 1'b0, 1'b0, 1'b0};
        end else begin
          slot = '{8'h00, 1'b1, 1'b1, 1'b1};
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sfcs_pkg::BackIdle: begin
        if (desc_valid_i) begin
          state_d = sfcs_pkg::BackRun;
        end
      end
      sfcs_pkg::BackRun: begin
        if (load && slot.last) begin
          state_d = sfcs_pkg::BackIdle;
        end
      end
      default: state_d = sfcs_pkg::BackIdle;
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o = 1'b0;
    load  = 1'b0;
    case (state_q)
      sfcs_pkg::BackIdle: pop_o = desc_valid_i;
      sfcs_pkg::BackRun:  load  = !out_valid_q || out_ready_i;
      default: begin
        pop_o = 1'b0;
        load  = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfcs_pkg::BackIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q <= '0;
      end else if (load) begin
        step_q <= step_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command and slot payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      desc_q <= desc_i;
    end
    if (load) begin
      out_q <= slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mosi_byte_o = out_q.mosi_byte;
  assign frame_end_o = out_q.frame_end;
  assign capture_o   = out_q.capture;
  assign last_o      = out_q.last;

`ifndef SYNTHESIS
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && slot.last) |=> (state_q == sfcs_pkg::BackIdle))
    else $error("sequencer did not return to idle after the last slot");

  a_capture_drives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && capture_o) |-> (mosi_byte_o == 8'h00))
    else $error("capture slot drives a nonzero byte");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == sfcs_pkg::BackIdle && !load))
    else $error("command taken from the queue while a command is running");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> frame_end_o)
    else $error("final slot of a request leaves chip select asserted");
`endif

endmodule

// File: rtl/spi_flash_command_sequencer_core.sv
// SPI flash command sequencer: each accepted request is turned into a series of
// byte slots (MSB-first bytes, chip select end marks and capture marks), one
// output transaction per slot. A request yields 2 to 37 slots; the sequencer
// produces one slot per clock while the output side keeps taking them, and
// returns to idle between requests to fetch the next command from the
// two-entry queue. The input side accepts requests while the queue has room,
// independent of the sequencer. Request code seven is accepted and produces no
// slots. The fast read setting takes effect at once and is meant to be written
// only while the block is idle.
module spi_flash_command_sequencer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_fast_read_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                opcode_i,
  input  logic [23:0]               address_i,
  input  logic [7:0]                data_first_i,
  input  logic [7:0]                data_second_i,
  input  logic [sfcs_pkg::LenW-1:0] read_length_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                mosi_byte_o,
  output logic                      frame_end_o,
  output logic                      capture_o,
  output logic                      last_o
);

  logic fast_read_q;
  sfcs_pkg::push_t push;
  logic push_ready;
  logic desc_valid;
  sfcs_pkg::desc_t desc;
  logic pop;

  // Configuration register write.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_read_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fast_read_q <= cfg_fast_read_i;
    end
  end

  sfcs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .address_i     (address_i),
    .data_first_i  (data_first_i),
    .data_second_i (data_second_i),
    .read_length_i (read_length_i),
    .push_o        (push),
    .push_ready_i  (push_ready)
  );

  sfcs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_valid_o  (desc_valid),
    .pop_desc_o   (desc),
    .pop_i        (pop)
  );

  sfcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fast_read_i  (fast_read_q),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mosi_byte_o  (mosi_byte_o),
    .frame_end_o  (frame_end_o),
    .capture_o    (capture_o),
    .last_o       (last_o)
  );

endmodule
